[rtl/stq_pkg.sv]
package stq_pkg;

  localparam int unsigned MaxTimers  = 16;
  localparam int unsigned IdW        = 4;
  localparam int unsigned CntW       = 5;
  localparam int unsigned MsPerTicks = 10;
  localparam int unsigned QDepth     = 2;
  localparam logic [63:0] ResetTime  = 64'h7FFF_FFFF_FFFF_FF00;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_PROC  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdW-1:0]  id;
    logic [31:0]     ticks;
    logic            rpt;
    logic [63:0]     now;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNLINK,
    ST_MUL,
    ST_FIND,
    ST_INSERT,
    ST_PHEAD,
    ST_PCHECK,
    ST_PEMIT,
    ST_REPORT
  } state_e;

endpackage

[rtl/sorted_timer_queue.sv]
// Channel | Signals                                        | Direction
// request | valid_i, stall_o, opcode_i .. now_ms_i         | in
// result  | valid_o, stall_i, kind_o .. last_o             | out
//
// A two-entry command queue takes requests while the sequencer works.
// A delete unlinks the timer; an add unlinks, multiplies the interval,
// sets the expiry and scans the queue entry by entry to insert. A process
// run reads the head, then emits each expired timer, re-inserting it first
// if it repeats, and then sends the report; a stalled result holds the run.
// Reset empties the queue and sets the stored time; results hold under stall.
module sorted_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  timer_id_i,
  input  logic [31:0] ticks_i,
  input  logic        repeat_req_i,
  input  logic [63:0] now_ms_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        kind_o,
  output logic [3:0]  expired_id_o,
  output logic [62:0] next_timeout_o,
  output logic        none_pending_o,
  output logic        last_o
);
  import stq_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  stq_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .opcode_i, .timer_id_i, .ticks_i,
    .repeat_req_i, .now_ms_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  stq_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .valid_o, .stall_i, .kind_o, .expired_id_o, .next_timeout_o,
    .none_pending_o, .last_o
  );
endmodule

[rtl/stq_front.sv]
module stq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [3:0]          timer_id_i,
  input  logic [31:0]         ticks_i,
  input  logic                repeat_req_i,
  input  logic [63:0]         now_ms_i,
  output logic                cmd_valid_o,
  input  logic                cmd_take_i,
  output stq_pkg::cmd_t       cmd_o
);
  import stq_pkg::*;

  cmd_t         mem_q [QDepth];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         push, pop, keep;
  cmd_t         c;

  always_comb begin
    c.op    = op_e'(opcode_i);
    c.id    = timer_id_i;
    c.ticks = ticks_i;
    c.rpt   = repeat_req_i;
    c.now   = now_ms_i;
    keep = !((c.op == OP_ADD || c.op == OP_DEL) && ({1'b0, timer_id_i} >= CntW'(MaxTimers)));
  end

  assign stall_o     = (cnt_q == 2'(QDepth));
  assign push        = valid_i && !stall_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/stq_back.sv]
module stq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_take_o,
  input  stq_pkg::cmd_t cmd_i,
  output logic          valid_o,
  input  logic          stall_i,
  output logic          kind_o,
  output logic [3:0]    expired_id_o,
  output logic [62:0]   next_timeout_o,
  output logic          none_pending_o,
  output logic          last_o
);
  import stq_pkg::*;

  state_e              state_q, state_d;
  logic [63:0]         expiry_q [MaxTimers];
  logic [31:0]         interval_q [MaxTimers];
  logic [MaxTimers-1:0] rpt_q;
  logic [MaxTimers-1:0] running_q, running_d;
  logic [IdW-1:0]      order_q [MaxTimers];
  logic [CntW-1:0]     count_q, count_d;
  logic [63:0]         time_q;
  cmd_t                cur_q;
  logic [IdW-1:0]      id_q, id_d;
  logic [CntW-1:0]     pos_q, pos_d;
  logic [63:0]         span_q;
  logic [63:0]         newexp_q;
  logic                ov_q, ov_d;
  logic                okind_q, onone_q;
  logic [IdW-1:0]      oid_q;
  logic [62:0]         ont_q;
  logic                ovalid_q;

  logic                out_free, emit;
  logic                do_unlink, do_insert, do_mul, set_exp, fire;
  logic                emit_rep, emit_ntf;
  logic [IdW-1:0]      head;
  logic [63:0]         diff, hexp, pexp, ndiff;
  logic [IdW:0]        upos;
  logic                ufound;

  assign out_free = !ovalid_q || !stall_i;
  assign head     = order_q[0];
  assign hexp     = expiry_q[head];
  assign pexp     = expiry_q[order_q[pos_q[IdW-1:0]]];
  assign diff     = hexp - time_q;
  assign ndiff    = newexp_q - pexp;

  always_comb begin
    ufound = 1'b0;
    upos   = '0;
    for (int i = 0; i < MaxTimers; i++) begin
      if (!ufound && (CntW'(i) < count_q) && order_q[i] == id_q) begin
        ufound = 1'b1;
        upos   = (IdW+1)'(i);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    id_d       = id_q;
    pos_d      = pos_q;
    ov_d       = 1'b0;
    cmd_take_o = 1'b0;
    do_unlink  = 1'b0;
    do_insert  = 1'b0;
    do_mul     = 1'b0;
    set_exp    = 1'b0;
    fire       = 1'b0;
    emit_rep   = 1'b0;
    emit_ntf   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          id_d = cmd_i.id;
          unique case (cmd_i.op)
            OP_ADD, OP_DEL: state_d = ST_UNLINK;
            OP_PROC:        state_d = ST_PHEAD;
            OP_CLEAR:       state_d = ST_IDLE;
            default:        state_d = ST_IDLE;
          endcase
        end
      end
      ST_UNLINK: begin
        do_unlink = 1'b1;
        state_d = (cur_q.op == OP_ADD) ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        do_mul = 1'b1;
        ov_d = ov_q;
        state_d = ST_FIND;
      end
      ST_FIND: begin
        set_exp = 1'b1;
        ov_d = ov_q;
        pos_d = '0;
        state_d = ST_INSERT;
      end
      ST_INSERT: begin
        ov_d = ov_q;
        if (pos_q < count_q && !ndiff[63]) begin
          pos_d = pos_q + 1'b1;
        end else begin
          do_insert = 1'b1;
          state_d = ov_q ? ST_PEMIT : ST_IDLE;
        end
      end
      ST_PHEAD: begin
        state_d = ST_PCHECK;
      end
      ST_PCHECK: begin
        if (count_q != 0 && diff[63]) begin
          fire = 1'b1;
          id_d = head;
          state_d = ST_PEMIT;
          if (rpt_q[head]) begin
            ov_d = 1'b1;
            state_d = ST_MUL;
          end
        end else begin
          state_d = ST_REPORT;
        end
      end
      ST_PEMIT: begin
        if (out_free) begin
          emit_ntf = 1'b1;
          state_d = ST_PCHECK;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          emit_rep = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic [63:0] prod;
  assign prod = 64'(interval_q[id_q]) * 64'(MsPerTicks);

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cur_q <= cmd_i;
    if (do_unlink && cur_q.op == OP_ADD) begin
      interval_q[id_q] <= cur_q.ticks;
      rpt_q[id_q] <= cur_q.rpt;
    end
    if (do_mul) span_q <= prod;
    if (set_exp) newexp_q <= time_q + span_q;
    if (set_exp) expiry_q[id_q] <= time_q + span_q;
    if (do_unlink && running_q[id_q] && ufound) begin
      for (int j = 0; j < MaxTimers - 1; j++) begin
        if ((IdW+1)'(j) >= upos) order_q[j] <= order_q[j+1];
      end
    end
    if (fire) begin
      for (int j = 0; j < MaxTimers - 1; j++) order_q[j] <= order_q[j+1];
    end
    if (do_insert && count_q < CntW'(MaxTimers)) begin
      for (int j = 1; j < MaxTimers; j++) begin
        if (CntW'(j) > pos_q && CntW'(j) <= count_q) order_q[j] <= order_q[j-1];
      end
      order_q[pos_q[IdW-1:0]] <= id_q;
    end
    if (emit_ntf || emit_rep) begin
      okind_q <= emit_rep;
      oid_q   <= emit_rep ? '0 : id_q;
      onone_q <= emit_rep && count_q == 0;
      ont_q   <= (emit_rep && count_q != 0 && !diff[63]) ? diff[62:0] : '0;
    end
  end

  always_comb begin
    running_d = running_q;
    count_d   = count_q;
    if (cmd_take_o && cmd_i.op == OP_CLEAR) begin
      running_d = '0;
      count_d = '0;
    end
    if (do_unlink && running_q[id_q]) begin
      running_d[id_q] = 1'b0;
      if (ufound) count_d = count_q - 1'b1;
    end
    if (fire) begin
      running_d[head] = 1'b0;
      count_d = count_q - 1'b1;
    end
    if (do_insert && count_q < CntW'(MaxTimers)) begin
      running_d[id_q] = 1'b1;
      count_d = count_q + 1'b1;
    end
  end

  assign emit = emit_ntf || emit_rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      running_q <= '0;
      count_q   <= '0;
      time_q    <= ResetTime;
      id_q      <= '0;
      pos_q     <= '0;
      ov_q      <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      count_q   <= count_d;
      id_q      <= id_d;
      pos_q     <= pos_d;
      ov_q      <= ov_d;
      if (cmd_take_o && cmd_i.op == OP_PROC) time_q <= cmd_i.now;
      if (emit) ovalid_q <= 1'b1;
      else if (!stall_i) ovalid_q <= 1'b0;
    end
  end

  assign valid_o        = ovalid_q;
  assign kind_o         = okind_q;
  assign expired_id_o   = oid_q;
  assign next_timeout_o = ont_q;
  assign none_pending_o = onone_q;
  assign last_o         = okind_q;
endmodule

[verif/stq_checker.sv]
module stq_checker
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  timer_id_i,
  input  logic [31:0] ticks_i,
  input  logic        repeat_req_i,
  input  logic [63:0] now_ms_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic        kind_o,
  input  logic [3:0]  expired_id_o,
  input  logic [62:0] next_timeout_o,
  input  logic        none_pending_o,
  input  logic        last_o,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [3:0]  id;
    logic [62:0] nt;
    logic        none;
    logic        last;
  } notice_t;

  logic [63:0] expiry_q [MaxTimers];
  logic [31:0] interval_q [MaxTimers];
  logic        repeat_q [MaxTimers];
  logic        running_q [MaxTimers];
  logic [3:0]  order_q [MaxTimers];
  int          count_q;
  logic [63:0] now_q;
  notice_t     expected_notices [$];

  function automatic logic is_earlier(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return d[63];
  endfunction

  function automatic void drop_timer(int id);
    int pos;
    if (!running_q[id]) return;
    pos = -1;
    for (int i = 0; i < count_q; i++)
      if (pos < 0 && order_q[i] == id) pos = i;
    if (pos >= 0) begin
      for (int j = pos; j + 1 < count_q; j++) order_q[j] = order_q[j+1];
      count_q--;
    end
    running_q[id] = 1'b0;
  endfunction

  function automatic void arm_timer(int id);
    int pos;
    expiry_q[id] = now_q + 64'(interval_q[id]) * 64'(MsPerTicks);
    pos = count_q;
    for (int i = count_q - 1; i >= 0; i--)
      if (is_earlier(expiry_q[id], expiry_q[order_q[i]])) pos = i;
    if (count_q >= MaxTimers) return;
    for (int j = count_q; j > pos; j--) order_q[j] = order_q[j-1];
    order_q[pos] = 4'(id);
    count_q++;
    running_q[id] = 1'b1;
  endfunction

  function automatic void predict_request(logic [1:0] op, logic [3:0] id,
                                          logic [31:0] tk, logic rp, logic [63:0] nw);
    int n;
    int head;
    logic [63:0] e;
    notice_t r;
    n = 0;
    case (op_e'(op))
      OP_ADD: begin
        drop_timer(id);
        interval_q[id] = tk;
        repeat_q[id] = rp;
        arm_timer(id);
      end
      OP_DEL: drop_timer(id);
      OP_CLEAR: begin
        for (int i = 0; i < MaxTimers; i++) running_q[i] = 1'b0;
        count_q = 0;
      end
      default: begin
        now_q = nw;
        while (count_q > 0 && n < 16) begin
          head = order_q[0];
          if (!is_earlier(expiry_q[head], now_q)) break;
          drop_timer(head);
          if (repeat_q[head]) arm_timer(head);
          r = '0;
          r.id = 4'(head);
          expected_notices.push_back(r);
          n++;
        end
        r = '0;
        r.kind = 1'b1;
        r.last = 1'b1;
        if (count_q == 0) r.none = 1'b1;
        else begin
          e = expiry_q[order_q[0]];
          r.nt = is_earlier(e, now_q) ? 63'd0 : 63'(e - now_q);
        end
        expected_notices.push_back(r);
      end
    endcase
  endfunction

  assign pending_count = expected_notices.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    notice_t x;
    if (!rst_ni) begin
      fail_count <= 0;
      count_q = 0;
      now_q = ResetTime;
      for (int i = 0; i < MaxTimers; i++) running_q[i] = 1'b0;
      expected_notices.delete();
    end else begin
      if (valid_i && !stall_o)
        predict_request(opcode_i, timer_id_i, ticks_i, repeat_req_i, now_ms_i);
      if (valid_o && !stall_i) begin
        if (expected_notices.size() == 0) begin
          $error("unexpected result kind=%0d id=%0d", kind_o, expired_id_o);
          fail_count <= fail_count + 1;
        end else begin
          x = expected_notices.pop_front();
          if (x.kind !== kind_o || x.id !== expired_id_o || x.nt !== next_timeout_o ||
              x.none !== none_pending_o || x.last !== last_o) begin
            if (x.kind !== kind_o) $error("kind exp %0d got %0d", x.kind, kind_o);
            if (x.id !== expired_id_o)
              $error("expired_id exp %0d got %0d", x.id, expired_id_o);
            if (x.nt !== next_timeout_o)
              $error("next_timeout exp %0d got %0d", x.nt, next_timeout_o);
            if (x.none !== none_pending_o)
              $error("none_pending exp %0d got %0d", x.none, none_pending_o);
            if (x.last !== last_o) $error("last exp %0d got %0d", x.last, last_o);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[verif/tb_sorted_timer_queue.sv]
module tb_sorted_timer_queue;
  import stq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  opcode_i = '0;
  logic [3:0]  timer_id_i = '0;
  logic [31:0] ticks_i = '0;
  logic        repeat_req_i = 1'b0;
  logic [63:0] now_ms_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        kind_o;
  logic [3:0]  expired_id_o;
  logic [62:0] next_timeout_o;
  logic        none_pending_o;
  logic        last_o;
  int          fail_count;
  int          pending_count;
  logic [63:0] clock_ms;

  sorted_timer_queue dut (.*);
  stq_checker u_checker (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(op_e op, logic [3:0] id, logic [31:0] tk,
                              logic rp, logic [63:0] nw);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    opcode_i <= op;
    timer_id_i <= id;
    ticks_i <= tk;
    repeat_req_i <= rp;
    now_ms_i <= nw;
    do @(posedge clk_i); while (stall_o);
  endtask

  task automatic advance_clock(int step);
    clock_ms = clock_ms + 64'(step);
    send_request(OP_PROC, 4'($urandom), $urandom, 1'($urandom), clock_ms);
  endtask

  initial begin
    int stall_left;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
        if (valid_o) stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      end
    end
  end

  initial begin
    int r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    clock_ms = ResetTime;
    send_request(OP_PROC, 4'hF, 32'hFFFF_FFFF, 1'b1, ResetTime);
    send_request(OP_DEL, 4'd3, 32'd0, 1'b0, 64'd0);
    send_request(OP_ADD, 4'd0, 32'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_ADD, 4'd15, 32'hFFFF_FFFF, 1'b0, 64'd0);
    send_request(OP_ADD, 4'd5, 32'd3, 1'b1, 64'd0);
    send_request(OP_ADD, 4'd6, 32'd3, 1'b0, 64'd0);
    send_request(OP_ADD, 4'd5, 32'd1, 1'b0, 64'd0);
    advance_clock(1);
    advance_clock(40);
    send_request(OP_DEL, 4'd15, 32'd0, 1'b0, 64'd0);
    advance_clock(0);
    for (int i = 0; i < 16; i++) send_request(OP_ADD, 4'(i), 32'(i % 3), 1'b1, 64'd0);
    advance_clock(1000);
    advance_clock(30);
    send_request(OP_CLEAR, 4'd0, 32'd0, 1'b0, 64'd0);
    advance_clock(5);
    clock_ms = 64'hFFFF_FFFF_FFFF_FFF0;
    send_request(OP_ADD, 4'd2, 32'd10, 1'b0, 64'd0);
    advance_clock(0);
    advance_clock(200);
    valid_i <= 1'b0;
    wait (pending_count == 0);
    repeat (100) @(posedge clk_i);
    for (int k = 0; k < 330; k++) begin
      r = $urandom_range(0, 9);
      if (r < 5) send_request(OP_ADD, 4'($urandom), ($urandom_range(0, 15) == 0) ?
                              $urandom : $urandom_range(0, 20), 1'($urandom),
                              64'($urandom));
      else if (r < 6) send_request(OP_DEL, 4'($urandom), $urandom, 1'($urandom),
                                   64'($urandom));
      else if (r < 7 && $urandom_range(0, 3) == 0)
        send_request(OP_CLEAR, 4'($urandom), $urandom, 1'($urandom), 64'($urandom));
      else if ($urandom_range(0, 20) == 0) begin
        clock_ms = {$urandom, $urandom};
        advance_clock(0);
      end else advance_clock($urandom_range(0, 120));
      if (k == 150) begin
        valid_i <= 1'b0;
        wait (pending_count == 0);
      end
    end
    valid_i <= 1'b0;
    wait (pending_count == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

[filelist.f]
rtl/stq_pkg.sv
rtl/stq_front.sv
rtl/stq_back.sv
rtl/sorted_timer_queue.sv
verif/stq_checker.sv
verif/tb_sorted_timer_queue.sv
